// ===== sv/rlf_pkg.sv =====
package rlf_pkg;

    localparam int unsigned RUN_DEPTH_DEFAULT = 64;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned ENTRY_W  = VALUE_W + COUNT_W;
    localparam int unsigned SUM_W    = 64;
    localparam int unsigned STATUS_W = 2;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_TAKE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TAKE_SHORT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic acc;
    } t_mac_ctl;

endpackage

// ===== sv/rlf_ram.sv =====
module rlf_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rlf_mac.sv =====
module rlf_mac (
    input  logic                          i_clk,
    input  rlf_pkg::t_mac_ctl             i_ctl,
    input  logic [rlf_pkg::VALUE_W-1:0]   i_value,
    input  logic [rlf_pkg::COUNT_W-1:0]   i_units,
    output logic [rlf_pkg::SUM_W-1:0]     o_sum
);

    localparam int unsigned SW = rlf_pkg::SUM_W;

    logic [rlf_pkg::VALUE_W-1:0] r_a;
    logic [rlf_pkg::COUNT_W-1:0] r_b;
    logic [rlf_pkg::SUM_W-1:0]   r_prod;
    logic [rlf_pkg::SUM_W-1:0]   r_sum;

    // Operands are captured first, the product is registered next cycle,
    // and the accumulator adds it in the cycle after that.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= i_value;
            r_b <= i_units;
        end
        r_prod <= SW'(r_a) * SW'(r_b);
        if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= r_sum + r_prod;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== sv/run_length_fifo_bulk_take_sum.sv =====
// FIFO of runs (value, repeat count) kept in one simple dual-port RAM of
// RUN_DEPTH entries. A push stores a run, and its result can be taken the
// cycle after acceptance. A take walks the head runs one at a time through
// a read, a 32x32 multiply and an accumulate, then posts the result once
// the output register is free. The block holds one transaction at a time,
// while a finished result may still wait in the output register. A full
// store drops the push with status 1; a take asking for more units than
// stored empties the store with status 2.
module run_length_fifo_bulk_take_sum #(
    parameter int unsigned RUN_DEPTH = rlf_pkg::RUN_DEPTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [rlf_pkg::VALUE_W-1:0]   i_run_value,
    input  logic [rlf_pkg::COUNT_W-1:0]   i_unit_count,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rlf_pkg::SUM_W-1:0]     o_taken_sum,
    output logic [rlf_pkg::STATUS_W-1:0]  o_status
);

    localparam int unsigned PW = $clog2(RUN_DEPTH);
    localparam int unsigned CW = $clog2(RUN_DEPTH + 1);

    rlf_pkg::t_state                r_state, n_state;
    logic [PW-1:0]                  r_head, n_head;
    logic [PW-1:0]                  r_tail, n_tail;
    logic [CW-1:0]                  r_count, n_count;
    logic [rlf_pkg::COUNT_W-1:0]    r_left, n_left;
    logic [rlf_pkg::STATUS_W-1:0]   r_status, n_status;
    logic                           r_ovalid, n_ovalid;
    logic [rlf_pkg::SUM_W-1:0]      r_osum, n_osum;
    logic [rlf_pkg::STATUS_W-1:0]   r_ostatus, n_ostatus;

    logic                           w_out_free;
    logic                           w_in_acc;
    logic                           w_full;
    logic                           w_we;
    logic [PW-1:0]                  w_waddr;
    logic [rlf_pkg::ENTRY_W-1:0]    w_wdata;
    logic                           w_re;
    logic [rlf_pkg::ENTRY_W-1:0]    w_rdata;
    logic [rlf_pkg::VALUE_W-1:0]    w_rv;
    logic [rlf_pkg::COUNT_W-1:0]    w_rc;
    logic [rlf_pkg::COUNT_W-1:0]    w_use;
    logic                           w_pop;
    logic [rlf_pkg::SUM_W-1:0]      w_sum;
    rlf_pkg::t_mac_ctl              w_mac;

    rlf_ram #(
        .WIDTH (rlf_pkg::ENTRY_W),
        .DEPTH (RUN_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    rlf_mac u_mac (
        .i_clk   (i_clk),
        .i_ctl   (w_mac),
        .i_value (w_rv),
        .i_units (w_use),
        .o_sum   (w_sum)
    );

    assign w_out_free = !r_ovalid || !i_stall;
    assign o_stall    = !((r_state == rlf_pkg::S_IDLE) && w_out_free);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_full     = (r_count == CW'(RUN_DEPTH));

    assign w_rv  = w_rdata[rlf_pkg::ENTRY_W-1:rlf_pkg::COUNT_W];
    assign w_rc  = w_rdata[rlf_pkg::COUNT_W-1:0];
    assign w_use = (w_rc < r_left) ? w_rc : r_left;
    assign w_pop = (w_use == w_rc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rlf_pkg::S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_left    <= n_left;
        r_status  <= n_status;
        r_osum    <= n_osum;
        r_ostatus <= n_ostatus;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_left    = r_left;
        n_status  = r_status;
        n_osum    = r_osum;
        n_ostatus = r_ostatus;
        n_ovalid  = r_ovalid && i_stall;
        w_we      = 1'b0;
        w_waddr   = r_tail;
        w_wdata   = {i_run_value, i_unit_count};
        w_re      = 1'b0;
        w_mac     = '0;

        case (r_state)
            rlf_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_func == rlf_pkg::FUNC_PUSH) begin
                        n_ovalid = 1'b1;
                        n_osum   = '0;
                        if (w_full) begin
                            n_ostatus = rlf_pkg::ST_PUSH_FULL;
                        end else begin
                            n_ostatus = rlf_pkg::ST_OK;
                            w_we      = 1'b1;
                            n_tail    = (r_tail == PW'(RUN_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                            n_count   = r_count + 1'b1;
                        end
                    end else begin
                        w_mac.clr = 1'b1;
                        n_left    = i_unit_count;
                        n_state   = rlf_pkg::S_CHECK;
                    end
                end
            end
            rlf_pkg::S_CHECK, rlf_pkg::S_ACC: begin
                // The accumulate of the previous run and the decision on the
                // next one share this cycle.
                w_mac.acc = (r_state == rlf_pkg::S_ACC);
                if (r_left == '0) begin
                    n_status = rlf_pkg::ST_OK;
                    n_state  = rlf_pkg::S_DONE;
                end else if (r_count == '0) begin
                    n_status = rlf_pkg::ST_TAKE_SHORT;
                    n_state  = rlf_pkg::S_DONE;
                end else begin
                    w_re    = 1'b1;
                    n_state = rlf_pkg::S_READ;
                end
            end
            rlf_pkg::S_READ: begin
                w_mac.load = 1'b1;
                n_left     = r_left - w_use;
                if (w_pop) begin
                    n_head  = (r_head == PW'(RUN_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end else begin
                    // Split run: the remainder stays at the head.
                    w_we    = 1'b1;
                    w_waddr = r_head;
                    w_wdata = {w_rv, w_rc - w_use};
                end
                n_state = rlf_pkg::S_MUL;
            end
            rlf_pkg::S_MUL: begin
                n_state = rlf_pkg::S_ACC;
            end
            rlf_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_ovalid  = 1'b1;
                    n_osum    = w_sum;
                    n_ostatus = r_status;
                    n_state   = rlf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rlf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_taken_sum = r_osum;
    assign o_status    = r_ostatus;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RUN_DEPTH))
        else $error("run count exceeds store depth");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_func == rlf_pkg::FUNC_PUSH && w_full)
        |=> (o_valid && o_status == rlf_pkg::ST_PUSH_FULL && $stable(r_count)))
        else $error("push to full store not flagged or not dropped");

    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlf_pkg::S_DONE && r_status == rlf_pkg::ST_OK) |-> (r_left == '0))
        else $error("take finished ok with units left");

endmodule

// ===== bench/run_length_fifo_bulk_take_sum_tb.sv =====
`timescale 1ns / 100ps

module run_length_fifo_bulk_take_sum_tb;

    localparam int unsigned DEPTH       = rlf_pkg::RUN_DEPTH_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam int unsigned SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [rlf_pkg::SUM_W-1:0]    sum;
        logic [rlf_pkg::STATUS_W-1:0] status;
    } t_take_outcome;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_valid      = 1'b0;
    logic                         i_func       = rlf_pkg::FUNC_PUSH;
    logic [rlf_pkg::VALUE_W-1:0]  i_run_value  = '0;
    logic [rlf_pkg::COUNT_W-1:0]  i_unit_count = '0;
    logic                         i_stall      = 1'b0;
    logic                         o_stall;
    logic                         o_valid;
    logic [rlf_pkg::SUM_W-1:0]    o_taken_sum;
    logic [rlf_pkg::STATUS_W-1:0] o_status;

    // Mirror of the run store used to predict each take.
    logic [rlf_pkg::VALUE_W-1:0] run_val_mem [DEPTH];
    logic [rlf_pkg::COUNT_W-1:0] run_cnt_mem [DEPTH];
    int unsigned        head_idx  = 0;
    int unsigned        tail_idx  = 0;
    int unsigned        held_runs = 0;

    t_take_outcome expected_outcomes[$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count    = 0;
    int unsigned   stall_wait     = 0;
    bit            no_idle        = 1'b0;

    run_length_fifo_bulk_take_sum #(
        .RUN_DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_run_value (i_run_value),
        .i_unit_count(i_unit_count),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_taken_sum (o_taken_sum),
        .o_status    (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_take_outcome predict_take_sum(logic func,
                                                       logic [rlf_pkg::VALUE_W-1:0] run_val,
                                                       logic [rlf_pkg::COUNT_W-1:0] units);
        t_take_outcome r;
        logic [rlf_pkg::COUNT_W-1:0] left;
        logic [rlf_pkg::COUNT_W-1:0] run_cnt;
        logic [rlf_pkg::COUNT_W-1:0] used;
        r.sum = '0;
        r.status = rlf_pkg::ST_OK;
        if (func == rlf_pkg::FUNC_PUSH) begin
            if (held_runs >= DEPTH) begin
                r.status = rlf_pkg::ST_PUSH_FULL;
            end else begin
                run_val_mem[tail_idx] = run_val;
                run_cnt_mem[tail_idx] = units;
                tail_idx = (tail_idx + 1) % DEPTH;
                held_runs++;
            end
        end else begin
            left = units;
            while (left != 0 && held_runs != 0) begin
                run_cnt = run_cnt_mem[head_idx];
                used = (run_cnt < left) ? run_cnt : left;
                r.sum += {32'd0, run_val_mem[head_idx]} * {32'd0, used};
                left -= used;
                // A run that is used up, including a zero-count run, leaves the head.
                if (used == run_cnt) begin
                    head_idx = (head_idx + 1) % DEPTH;
                    held_runs--;
                end else begin
                    run_cnt_mem[head_idx] = run_cnt - used;
                end
            end
            if (left != 0)
                r.status = rlf_pkg::ST_TAKE_SHORT;
        end
        return r;
    endfunction

    function automatic logic [63:0] held_units();
        logic [63:0] total;
        total = '0;
        for (int unsigned k = 0; k < held_runs; k++)
            total += {32'd0, run_cnt_mem[(head_idx + k) % DEPTH]};
        return total;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_item(logic func, logic [rlf_pkg::VALUE_W-1:0] run_val,
                             logic [rlf_pkg::COUNT_W-1:0] units);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= func;
        i_run_value  <= run_val;
        i_unit_count <= units;
        do @(posedge i_clk); while (o_stall);
        expected_outcomes.insert(expected_outcomes.size(),
                                 predict_take_sum(func, run_val, units));
    endtask

    // The sender stops until every outstanding result has been returned.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_outcomes.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch($sformatf("unexpected result sum=%h status=%0d",
                                          o_taken_sum, o_status));
            end else begin
                if (o_taken_sum !== expected_outcomes[0].sum)
                    report_mismatch($sformatf("taken_sum %h, expected %h",
                                              o_taken_sum, expected_outcomes[0].sum));
                if (o_status !== expected_outcomes[0].status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, expected_outcomes[0].status));
                expected_outcomes.delete(0);
            end
            stall_wait = no_idle ? 0 : $urandom_range(0, 3);
        end
        if (stall_wait > 0) begin
            i_stall <= 1'b1;
            stall_wait--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic test_corner_cases();
        send_item(rlf_pkg::FUNC_TAKE, 32'd0, 32'd0);          // zero take on an empty store
        send_item(rlf_pkg::FUNC_TAKE, 32'hFFFF_FFFF, 32'd5);  // take from an empty store
        send_item(rlf_pkg::FUNC_PUSH, 32'd0, 32'd0);          // zero-count run
        send_item(rlf_pkg::FUNC_TAKE, 32'd0, 32'd0);          // zero take keeps it at the head
        send_item(rlf_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(rlf_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(rlf_pkg::FUNC_TAKE, 32'd0, 32'd1);          // drops the zero run, splits the next
        send_item(rlf_pkg::FUNC_TAKE, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // spans two runs
        send_item(rlf_pkg::FUNC_TAKE, 32'd0, 32'hFFFF_FFFF);  // more than the store holds
        send_item(rlf_pkg::FUNC_PUSH, 32'h1234_5678, 32'd1);
        send_item(rlf_pkg::FUNC_PUSH, 32'hAAAA_AAAA, 32'h5555_5555);
        send_item(rlf_pkg::FUNC_PUSH, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(rlf_pkg::FUNC_PUSH, 32'd7, 32'd0);
        send_item(rlf_pkg::FUNC_TAKE, 32'd0, 32'd1);
        send_item(rlf_pkg::FUNC_TAKE, 32'd0, 32'h5555_5555);  // ends exactly on a run boundary
        send_item(rlf_pkg::FUNC_TAKE, 32'd0, 32'hAAAA_AAAA);  // leaves the zero-count run behind
        send_item(rlf_pkg::FUNC_TAKE, 32'd0, 32'd1);          // zero run alone cannot satisfy it
        hold_until_drained();
    endtask

    task automatic test_full_store();
        logic [63:0] total;
        send_item(rlf_pkg::FUNC_TAKE, $urandom, 32'hFFFF_FFFF);
        while (held_runs < DEPTH)
            send_item(rlf_pkg::FUNC_PUSH, $urandom, $urandom_range(0, 8));
        repeat (3)
            send_item(rlf_pkg::FUNC_PUSH, $urandom, $urandom);  // dropped, store is full
        send_item(rlf_pkg::FUNC_TAKE, $urandom, 32'd0);
        total = held_units();
        send_item(rlf_pkg::FUNC_TAKE, $urandom, total[rlf_pkg::COUNT_W-1:0]); // takes every held unit
        send_item(rlf_pkg::FUNC_TAKE, $urandom, 32'd1);
        hold_until_drained();
    endtask

    task automatic test_random_mix(int unsigned count, int unsigned push_pct);
        logic [rlf_pkg::VALUE_W-1:0] run_val;
        logic [rlf_pkg::COUNT_W-1:0] units;
        logic [63:0]                 total;
        int unsigned                 pick;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            run_val = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
            if ($urandom_range(1, 100) <= push_pct) begin
                units = (pick == 0) ? 32'd0 :
                        (pick == 1) ? $urandom : $urandom_range(1, 16);
                send_item(rlf_pkg::FUNC_PUSH, run_val, units);
            end else begin
                total = held_units();
                if (pick == 0)
                    units = 32'd0;
                else if (pick == 1)
                    units = $urandom;
                else if (pick == 2 && total <= 64'hFFFF_FFFF)
                    units = total[rlf_pkg::COUNT_W-1:0];
                else
                    units = $urandom_range(1, 48);
                send_item(rlf_pkg::FUNC_TAKE, run_val, units);
            end
        end
        hold_until_drained();
    endtask

    task automatic test_back_to_back(int unsigned count);
        no_idle = 1'b1;
        test_random_mix(count, 50);
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_cases();
        test_full_store();
        test_random_mix(450, 70);
        test_full_store();
        test_random_mix(400, 30);
        test_back_to_back(300);
        test_random_mix(330, 55);
        test_full_store();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_outcomes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
